// ===== hdl/lfp_pkg.sv =====
package lfp_pkg;

  // header layout, little-endian byte offsets
  localparam int HEADER_BYTES = 30;
  localparam int OFF_MAGIC    = 0;
  localparam int OFF_MAJOR    = 4;
  localparam int OFF_MTYPE    = 8;
  localparam int OFF_FLAGS    = 10;
  localparam int OFF_REQ_ID   = 14;
  localparam int OFF_LENGTH   = 22;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_MAGIC  = 2'd0;
  localparam logic [1:0] ERR_MAJOR  = 2'd1;
  localparam logic [1:0] ERR_LENGTH = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MAGIC   = 2'd0;
  localparam logic [1:0] REG_MAJOR   = 2'd1;
  localparam logic [1:0] REG_MAX_LEN = 2'd2;

  typedef struct packed {
    logic [15:0] message_type;
    logic [31:0] flags;
    logic [63:0] request_id;
    logic [63:0] length;
  } hdr_fields_t;

  typedef struct packed {
    logic        pass;
    logic [1:0]  err;
    hdr_fields_t fields;
  } hdr_verdict_t;

endpackage

// ===== hdl/lfp_hdr_check.sv =====
module lfp_hdr_check import lfp_pkg::*; (
  input  logic [HEADER_BYTES*8-1:0] hdr_vec,
  input  logic [31:0]               expected_magic,
  input  logic [15:0]               expected_major,
  input  logic [31:0]               max_payload_len,
  output hdr_verdict_t              verdict
);

  logic [31:0] magic;
  logic [15:0] major;
  logic [63:0] length;
  logic        len_too_big;

  // field extraction
  assign magic  = hdr_vec[OFF_MAGIC*8 +: 32];
  assign major  = hdr_vec[OFF_MAJOR*8 +: 16];
  assign length = hdr_vec[OFF_LENGTH*8 +: 64];

  // full 64-bit length against the 32-bit limit
  assign len_too_big = (length[63:32] != 32'd0) || (length[31:0] > max_payload_len);

  // checks in order magic, major, length
  always_comb begin
    verdict.fields.message_type = hdr_vec[OFF_MTYPE*8 +: 16];
    verdict.fields.flags        = hdr_vec[OFF_FLAGS*8 +: 32];
    verdict.fields.request_id   = hdr_vec[OFF_REQ_ID*8 +: 64];
    verdict.fields.length       = length;
    verdict.pass = 1'b0;
    verdict.err  = ERR_MAGIC;
    priority if (magic != expected_magic) begin
      verdict.err = ERR_MAGIC;
    end else if (major != expected_major) begin
      verdict.err = ERR_MAJOR;
    end else if (len_too_big) begin
      verdict.err = ERR_LENGTH;
    end else begin
      verdict.pass = 1'b1;
    end
  end

endmodule

// ===== hdl/length_prefixed_frame_parser.sv =====
// a byte goes to the input register, then its result to the result register
// throughput: one byte per cycle unless the output stalls; the header check and
// payload count take one pass between the input register and the result register
// input is held back only while a byte that yields a result meets a stalled output
// reset: synchronous; clears phase, counters, config and valid flags; the
// header buffer is not cleared since every header overwrites it before use
module length_prefixed_frame_parser import lfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  // result requests
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [15:0] message_type,
  output logic [31:0] header_flags,
  output logic [63:0] request_id,
  output logic [31:0] payload_len,
  output logic [7:0]  data_byte,
  output logic        last_of_frame,
  output logic [1:0]  error_code
);

  logic [31:0] expected_magic;
  logic [15:0] expected_major;
  logic [31:0] max_payload_len;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        phase;
  logic [4:0]  hdr_count;
  logic [31:0] remaining;
  logic [7:0]  hdr_buf [0:HEADER_BYTES-2];

  logic [HEADER_BYTES*8-1:0] hdr_vec;
  hdr_verdict_t verdict;

  logic last_hdr;
  logic need_out;
  logic out_free;
  logic s1_adv;
  logic out_load;
  logic in_fire;

  // assembled header, final byte straight from the input register
  for (genvar i = 0; i < HEADER_BYTES - 1; i++) begin : g_hdr
    assign hdr_vec[i*8 +: 8] = hdr_buf[i];
  end
  assign hdr_vec[(HEADER_BYTES-1)*8 +: 8] = s1_byte;

  lfp_hdr_check u_check (
    .hdr_vec         (hdr_vec),
    .expected_magic  (expected_magic),
    .expected_major  (expected_major),
    .max_payload_len (max_payload_len),
    .verdict         (verdict)
  );

  // flow control
  assign last_hdr = !phase && (hdr_count == 5'(HEADER_BYTES - 1));
  assign need_out = phase || last_hdr;
  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && (!need_out || out_free);
  assign out_load = s1_adv && need_out;
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic  <= '0;
      expected_major  <= '0;
      max_payload_len <= '0;
      s1_valid        <= 1'b0;
      phase           <= 1'b0;
      hdr_count       <= '0;
      remaining       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MAGIC:   expected_magic  <= cfg_data;
          REG_MAJOR:   expected_major  <= cfg_data[15:0];
          REG_MAX_LEN: max_payload_len <= cfg_data;
          default:     ;
        endcase
      end

      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        if (phase) begin
          remaining <= remaining - 32'd1;
          if (remaining == 32'd1) begin
            phase <= 1'b0;
          end
        end else if (last_hdr) begin
          hdr_count <= '0;
          if (verdict.pass && (verdict.fields.length != 64'd0)) begin
            phase     <= 1'b1;
            remaining <= verdict.fields.length[31:0];
          end
        end else begin
          hdr_count <= hdr_count + 5'd1;
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // input byte and header buffer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte <= byte_in;
    end
    if (s1_adv && !phase && !last_hdr) begin
      hdr_buf[hdr_count] <= s1_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind   <= KIND_DATA;
      message_type  <= '0;
      header_flags  <= '0;
      request_id    <= '0;
      payload_len   <= '0;
      data_byte     <= '0;
      last_of_frame <= 1'b0;
      error_code    <= '0;
      if (phase) begin
        data_byte     <= s1_byte;
        last_of_frame <= (remaining == 32'd1);
      end else if (verdict.pass) begin
        result_kind   <= KIND_HEADER;
        message_type  <= verdict.fields.message_type;
        header_flags  <= verdict.fields.flags;
        request_id    <= verdict.fields.request_id;
        payload_len   <= verdict.fields.length[31:0];
        last_of_frame <= (verdict.fields.length == 64'd0);
      end else begin
        result_kind <= KIND_ERROR;
        error_code  <= verdict.err;
      end
    end
  end

`ifndef SYNTH
  // header counter is idle during payload
  a_phase_count: assert property (@(posedge clk) disable iff (rst)
    phase |-> (hdr_count == 5'd0))
    else $error("header count not zero in payload phase");

  // payload phase always has bytes left
  a_remaining: assert property (@(posedge clk) disable iff (rst)
    phase |-> (remaining != 32'd0))
    else $error("payload phase with nothing remaining");

  // counter stays inside the header
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    hdr_count < 5'(HEADER_BYTES))
    else $error("header count beyond header length");

  // an accepted header with payload moves to the payload phase
  a_enter_payload: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_hdr && verdict.pass && (verdict.fields.length != 64'd0))
    |=> phase && out_valid && (result_kind == KIND_HEADER) && !last_of_frame)
    else $error("header with payload did not enter payload phase");

  // an error result never closes a frame
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == KIND_ERROR)) |-> !last_of_frame)
    else $error("error result marked as last of frame");
`endif

endmodule
